@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside reset.
`define RPA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define RPA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define RPA_ASSERT(label, clk, rst, prop)
`define RPA_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ hw/rtl/rpa_pkg.sv @@
package rpa_pkg;

  localparam int unsigned PAGES      = 32768;
  localparam int unsigned COUNT_BITS = 8;
  localparam int unsigned IDX_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned DEPTH_W    = $clog2(PAGES + 1);
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PG_W       = 32 - PAGE_SHIFT;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [DEPTH_W-1:0]    depth_t;

  localparam count_t COUNT_MAX = '1;

  localparam logic [2:0] ACT_ALLOC  = 3'd0;
  localparam logic [2:0] ACT_FREE   = 3'd1;
  localparam logic [2:0] ACT_INCREF = 3'd2;
  localparam logic [2:0] ACT_GETREF = 3'd3;
  localparam logic [2:0] ACT_DONATE = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_PAGE  = 3'd1,
    ST_MISALIGN = 3'd2,
    ST_RANGE    = 3'd3,
    ST_ZERO     = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    REG_REGION_BASE  = 1'b0,
    REG_USABLE_START = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] page_addr;
  } rpa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] alloc_addr;
    logic [7:0]  ref_count;
    logic        page_freed;
  } rpa_out_t;

  typedef struct packed {
    status_t status;
    idx_t    idx;
  } chk_t;

  function automatic logic [7:0] count_out(count_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[7:0];
  endfunction

endpackage

@@ hw/rtl/rpa_ram.sv @@
module rpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rpa_addr_check.sv @@
module rpa_addr_check (
  input  logic [31:0]   page_addr,
  input  logic [31:0]   base,
  input  logic [31:0]   usable_start,
  input  logic          need_usable,
  output rpa_pkg::chk_t chk
);
  import rpa_pkg::*;

  logic [31:0]   diff;
  logic [PG_W:0] pg;
  logic          in_span;

  always_comb begin
    diff    = page_addr - base;
    pg      = {1'b0, diff[31:PAGE_SHIFT]};
    in_span = pg < (PG_W + 1)'(PAGES);
    chk.idx = pg[IDX_W-1:0];
    if (page_addr[PAGE_SHIFT-1:0] != '0) begin
      chk.status = ST_MISALIGN;
    end else if (page_addr < base || (need_usable && page_addr < usable_start) ||
                 !in_span) begin
      chk.status = ST_RANGE;
    end else begin
      chk.status = ST_OK;
    end
  end

endmodule

@@ hw/rtl/refcounted_page_allocator.sv @@
// Reference-counted page frame allocator.
// Input channel (in_valid/in_ready/in_data) carries one action per transfer:
// alloc, free, incref, getref or donate, with a page byte address.
// Output channel (out_valid/out_ready/out_data) returns exactly one result per
// action, in order: status, allocated address, count after the action and a
// flag for a page pushed onto the free stack.
// Each action is a read-modify-write: the count and free-stack RAMs
// are read in the transfer cycle and written back the cycle after, when the
// result enters the output register. A new action is taken only after the
// previous one has been written back. Between input transfer and out_valid the
// action passes the x_ registers and then the output register.
// A stalled receiver holds the result in the output register; no new action
// is taken until that result has been transferred or is being transferred.
// Reset (rst, synchronous) empties the stack, restores both registers and
// then clears all PAGES (32768) entries of the count RAM, one entry per cycle,
// with in_ready low. Configuration writes (cfg_we) are taken at any time.
module refcounted_page_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_addr,
  input  logic [31:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  rpa_pkg::rpa_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rpa_pkg::rpa_out_t out_data
);
  import rpa_pkg::*;

  logic [31:0] region_base;
  logic [31:0] usable_start;
  logic [31:0] base_al;

  state_t   state;
  state_t   state_next;
  idx_t     clr_idx;
  depth_t   depth;
  depth_t   depth_next;
  depth_t   depth_m1;

  logic       x_action_ld;
  logic [2:0] x_action;
  status_t    x_status;
  idx_t       x_idx;

  chk_t     chk;
  logic     need_usable;
  logic     in_xfer;

  logic     cnt_we;
  idx_t     cnt_waddr;
  count_t   cnt_wdata;
  count_t   cnt_rdata;
  logic     stk_we;
  idx_t     stk_waddr;
  idx_t     stk_rdata;
  idx_t     pop_idx;
  logic     can_push;
  count_t   cnt_dec;
  count_t   cnt_inc;
  rpa_out_t res;

  assign base_al     = {region_base[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign in_xfer     = in_valid && in_ready;
  assign need_usable = in_data.action inside {ACT_FREE, ACT_DONATE};
  assign depth_m1    = depth - depth_t'(1);
  assign can_push    = depth < depth_t'(PAGES);
  assign pop_idx     = (32'(stk_rdata) >= 32'(PAGES)) ? '0 : stk_rdata;
  assign cnt_dec     = cnt_rdata - count_t'(1);
  assign cnt_inc     = cnt_rdata + count_t'(1);

  rpa_addr_check u_check (
    .page_addr    (in_data.page_addr),
    .base         (base_al),
    .usable_start (usable_start),
    .need_usable  (need_usable),
    .chk          (chk)
  );

  rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAGES)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (in_xfer),
    .raddr (chk.idx),
    .rdata (cnt_rdata)
  );

  rpa_ram #(.WIDTH(IDX_W), .DEPTH(PAGES)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (x_idx),
    .re    (in_xfer),
    .raddr (depth_m1[IDX_W-1:0]),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= 32'h8000_0000;
      usable_start <= 32'h8000_0000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_REGION_BASE:  region_base  <= cfg_data;
        REG_USABLE_START: usable_start <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + idx_t'(1);
      end
      if (state == S_EXEC) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_action_ld) begin
      x_action <= in_data.action;
      x_status <= chk.status;
      x_idx    <= chk.idx;
    end
    if (state == S_EXEC) begin
      out_data <= res;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    x_action_ld = 1'b0;
    depth_next  = depth;
    cnt_we      = 1'b0;
    cnt_waddr   = x_idx;
    cnt_wdata   = '0;
    stk_we      = 1'b0;
    stk_waddr   = depth[IDX_W-1:0];
    res         = '0;
    case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx;
        if (clr_idx == idx_t'(PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = !out_valid || out_ready;
        x_action_ld = in_xfer;
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (x_action)
          ACT_ALLOC: begin
            if (depth == '0) begin
              res.status = ST_NO_PAGE;
            end else begin
              depth_next     = depth_m1;
              cnt_we         = 1'b1;
              cnt_waddr      = pop_idx;
              cnt_wdata      = count_t'(1);
              res.alloc_addr = base_al + (32'(pop_idx) << PAGE_SHIFT);
              res.ref_count  = count_out(count_t'(1));
            end
          end
          ACT_FREE: begin
            if (x_status != ST_OK) begin
              res.status = x_status;
            end else if (cnt_rdata == '0) begin
              res.status = ST_ZERO;
            end else begin
              cnt_we        = 1'b1;
              cnt_wdata     = cnt_dec;
              res.ref_count = count_out(cnt_dec);
              if (cnt_dec == '0 && can_push) begin
                stk_we         = 1'b1;
                depth_next     = depth + depth_t'(1);
                res.page_freed = 1'b1;
              end
            end
          end
          ACT_INCREF: begin
            if (x_status != ST_OK) begin
              res.status = x_status;
            end else if (cnt_rdata == COUNT_MAX) begin
              res.status    = ST_OVERFLOW;
              res.ref_count = count_out(COUNT_MAX);
            end else begin
              cnt_we        = 1'b1;
              cnt_wdata     = cnt_inc;
              res.ref_count = count_out(cnt_inc);
            end
          end
          ACT_GETREF: begin
            if (x_status != ST_OK) begin
              res.status = x_status;
            end else begin
              res.ref_count = count_out(cnt_rdata);
            end
          end
          ACT_DONATE: begin
            if (x_status != ST_OK) begin
              res.status = x_status;
            end else begin
              cnt_we = 1'b1;
              if (can_push) begin
                stk_we         = 1'b1;
                depth_next     = depth + depth_t'(1);
                res.page_freed = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

`include "assert_macros.svh"

  `RPA_ASSERT(a_exec_out_free, clk, rst, (state == S_EXEC) |-> !out_valid)
  `RPA_ASSERT(a_xfer_to_exec, clk, rst, (in_valid && in_ready) |=> (state == S_EXEC))
  `RPA_ASSERT(a_no_take_in_clear, clk, rst, (state == S_CLEAR) |-> !in_ready)
  `RPA_ASSERT(a_depth_only_in_exec, clk, rst, !$past(state == S_EXEC) |-> $stable(depth))
  `RPA_ASSERT_ALWAYS(a_depth_bound, clk, rst || (depth <= depth_t'(PAGES)))

endmodule
